FILE: design/packet_jitter_tracker_defines.svh
// Assertion helpers for packet_jitter_tracker.
`ifndef PACKET_JITTER_TRACKER_DEFINES_SVH
`define PACKET_JITTER_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PJT_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("packet_jitter_tracker: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PJT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("packet_jitter_tracker: next-cycle check failed");

`endif

FILE: design/pjt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pjt_pkg;

   localparam int FRAC_BITS  = 8;
   localparam int TIME_W     = 32;
   localparam int SEQ_W      = 32;
   localparam int DEV_W      = 32;
   localparam int TF_W       = 11;
   localparam int FP_W       = 20;
   localparam int ACC_W      = DEV_W + FRAC_BITS;
   localparam int OUT_W      = 39;
   localparam int DIV_CNT_W  = $clog2(ACC_W + 1);
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_TIME_FACTOR  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_PERIOD = CSR_IDX_W'(1);

   localparam logic [TF_W-1:0] TF_RESET = TF_W'(16);
   localparam logic [FP_W-1:0] FP_RESET = FP_W'(20000);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_DEV  = 6'b000100,
      ST_SUB  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   typedef struct packed {
      logic accept;
      logic mul;
      logic dev;
      logic sub;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic div_idle;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

FILE: design/pjt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pjt_req_if;
   import pjt_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] receive_time;
   logic [SEQ_W-1:0]  sequence_req;
   modport source (output valid, output receive_time, output sequence_req, input ready);
   modport sink   (input valid, input receive_time, input sequence_req, output ready);
endinterface

interface pjt_rsp_if;
   import pjt_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [DEV_W-1:0] deviation;
   logic [OUT_W-1:0]        late_average;
   logic [OUT_W-1:0]        early_average;
   logic [OUT_W-1:0]        margin;
   modport source (output valid, output deviation, output late_average,
                   output early_average, output margin, input ready);
   modport sink   (input valid, input deviation, input late_average,
                   input early_average, input margin, output ready);
endinterface

interface pjt_csr_if;
   import pjt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: design/packet_jitter_tracker.sv
// packet_jitter_tracker: per-packet arrival deviation and late/early jitter averages.
// req_ch carries one packet beat: receive_time (us) and sequence_req. The first
// beat after reset latches the reference time and sequence.
// rsp_ch returns one beat per packet: signed deviation, late and early averages
// and their mean margin, all averages unsigned Q31.8, saturated at 2^39-1.
// csr_ch writes time_factor (index 0) and frame_period (index 1); it is always
// ready and other indexes are dropped. Write it only while the block is idle.
// Each packet passes a sequence multiply, deviation, setup step and two parallel
// bit-serial dividers by time_factor (zero taken as one); one packet is in flight,
// so a new request is taken only once the previous packet has left its final step.
// The response sits in an output register; the next request is accepted while
// it waits. If rsp_ch stays stalled, the following packet holds in its final
// step until the register frees, and req_ch ready stays low meanwhile.
// Reset (synchronous, active high) restores register defaults, clears the
// reference and both averages, and drops any pending response.
`timescale 1ns / 1ps
`default_nettype none
`include "packet_jitter_tracker_defines.svh"
module packet_jitter_tracker (
   input  wire logic  clock,
   input  wire logic  reset,
   pjt_req_if.sink    req_ch,
   pjt_rsp_if.source  rsp_ch,
   pjt_csr_if.sink    csr_ch
);
   import pjt_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   pjt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pjt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .req_receive_time  (req_ch.receive_time),
      .req_sequence_req  (req_ch.sequence_req),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_deviation     (rsp_ch.deviation),
      .rsp_late_average  (rsp_ch.late_average),
      .rsp_early_average (rsp_ch.early_average),
      .rsp_margin        (rsp_ch.margin)
   );

   assign req_ch.ready = req_ready;
   assign csr_ch.ready = 1'b1;

   `PJT_ASSERT_NEXT(a_one_in_flight, clock, reset, cmd.accept, !req_ready)
   `PJT_ASSERT_SAME(a_start_when_idle, clock, reset, cmd.sub, status.div_idle)
   `PJT_ASSERT_NEXT(a_div_runs, clock, reset, cmd.sub, !status.div_idle)
   `PJT_ASSERT_NEXT(a_finish_shows, clock, reset, cmd.finish, rsp_ch.valid)

endmodule
`default_nettype wire

FILE: design/pjt_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module pjt_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [pjt_pkg::ACC_W-1:0]  dividend,
   input  wire logic [pjt_pkg::TF_W-1:0]   divisor,
   output logic                            busy,
   output logic [pjt_pkg::ACC_W-1:0]       quotient,
   output logic [pjt_pkg::TF_W-1:0]        remainder
);
   import pjt_pkg::*;

   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [TF_W-1:0]      rem_ff, rem_in;
   logic [TF_W-1:0]      dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic [TF_W:0]        trial;
   logic [TF_W:0]        trial_sub;
   logic                 fits;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      trial     = {rem_ff, quo_ff[ACC_W-1]};
      trial_sub = trial - {1'b0, dsr_ff};
      fits      = trial >= {1'b0, dsr_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DIV_CNT_W'(ACC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ACC_W-2:0], fits};
         rem_in = fits ? trial_sub[TF_W-1:0] : trial[TF_W-1:0];
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

FILE: design/pjt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pjt_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire pjt_pkg::cmd_type                  cmd,
   output pjt_pkg::status_type                    status,
   input  wire logic                              csr_we,
   input  wire logic [pjt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [pjt_pkg::CSR_DATA_W-1:0]    csr_data,
   input  wire logic [pjt_pkg::TIME_W-1:0]        req_receive_time,
   input  wire logic [pjt_pkg::SEQ_W-1:0]         req_sequence_req,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [pjt_pkg::DEV_W-1:0]       rsp_deviation,
   output logic [pjt_pkg::OUT_W-1:0]              rsp_late_average,
   output logic [pjt_pkg::OUT_W-1:0]              rsp_early_average,
   output logic [pjt_pkg::OUT_W-1:0]              rsp_margin
);
   import pjt_pkg::*;

   localparam logic [ACC_W:0] OUT_MAX = {{(ACC_W + 1 - OUT_W){1'b0}}, {OUT_W{1'b1}}};

   function automatic logic [OUT_W-1:0] sat_out(input logic [ACC_W:0] v);
      logic [OUT_W-1:0] r;
      r = (v > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : v[OUT_W-1:0];
      return r;
   endfunction

   logic [TF_W-1:0]   tf_ff;
   logic [FP_W-1:0]   fp_ff;
   logic [TIME_W-1:0] rt_ff;
   logic [SEQ_W-1:0]  seq_ff;
   logic              taken_ff;
   logic [TIME_W-1:0] ref_time_ff;
   logic [SEQ_W-1:0]  ref_seq_ff;
   logic [DEV_W-1:0]  prod_ff, prod_in;
   logic [DEV_W-1:0]  dev_ff, dev_in;
   logic [ACC_W-1:0]  late_ff, late_in;
   logic [ACC_W-1:0]  early_ff, early_in;
   logic              late_ge_ff, late_ge_in;
   logic              early_ge_ff, early_ge_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DEV_W-1:0]  out_dev_ff;
   logic [OUT_W-1:0]  out_late_ff, out_early_ff, out_margin_ff;

   logic [TF_W-1:0]      weight;
   logic [SEQ_W-1:0]     seq_diff;
   logic [FP_W+SEQ_W-1:0] prod_full;
   logic                 positive;
   logic [DEV_W-1:0]     mag;
   logic [ACC_W-1:0]     sample, late_sample, early_sample;
   logic [ACC_W-1:0]     late_diff, early_diff;
   logic                 late_busy, early_busy;
   logic [ACC_W-1:0]     late_q, early_q;
   logic [TF_W-1:0]      late_r, early_r;
   logic [ACC_W:0]       acc_sum;

   assign weight = (tf_ff == '0) ? TF_W'(1) : tf_ff;

   always_comb begin
      seq_diff  = seq_ff - (taken_ff ? ref_seq_ff : seq_ff);
      prod_full = {{SEQ_W{1'b0}}, fp_ff} * {{FP_W{1'b0}}, seq_diff};
      prod_in   = prod_full[DEV_W-1:0];
      dev_in    = rt_ff - ref_time_ff - prod_ff;
   end

   // blend: old + (s-old)/n when s >= old, else old - ceil((old-s)/n)
   always_comb begin
      positive     = (dev_ff != '0) && !dev_ff[DEV_W-1];
      mag          = positive ? dev_ff : (DEV_W'(0) - dev_ff);
      sample       = {mag, {FRAC_BITS{1'b0}}};
      late_sample  = positive ? sample : '0;
      early_sample = positive ? '0 : sample;
      late_ge_in   = late_sample >= late_ff;
      early_ge_in  = early_sample >= early_ff;
      late_diff    = late_ge_in ? (late_sample - late_ff) : (late_ff - late_sample);
      early_diff   = early_ge_in ? (early_sample - early_ff) : (early_ff - early_sample);
      late_in      = late_ge_ff ? (late_ff + late_q)
                                : (late_ff - late_q - ACC_W'(late_r != '0));
      early_in     = early_ge_ff ? (early_ff + early_q)
                                 : (early_ff - early_q - ACC_W'(early_r != '0));
      acc_sum      = {1'b0, late_in} + {1'b0, early_in};
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   pjt_divider u_late_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.sub),
      .dividend  (late_diff),
      .divisor   (weight),
      .busy      (late_busy),
      .quotient  (late_q),
      .remainder (late_r)
   );

   pjt_divider u_early_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.sub),
      .dividend  (early_diff),
      .divisor   (weight),
      .busy      (early_busy),
      .quotient  (early_q),
      .remainder (early_r)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tf_ff        <= TF_RESET;
         fp_ff        <= FP_RESET;
         taken_ff     <= 1'b0;
         late_ff      <= '0;
         early_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_TIME_FACTOR:  tf_ff <= csr_data[TF_W-1:0];
               REG_FRAME_PERIOD: fp_ff <= csr_data[FP_W-1:0];
               default: ;
            endcase
         end
         if (cmd.mul) begin
            taken_ff <= 1'b1;
         end
         if (cmd.finish) begin
            late_ff  <= late_in;
            early_ff <= early_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rt_ff  <= req_receive_time;
         seq_ff <= req_sequence_req;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         if (!taken_ff) begin
            ref_time_ff <= rt_ff;
            ref_seq_ff  <= seq_ff;
         end
      end
      if (cmd.dev) begin
         dev_ff <= dev_in;
      end
      if (cmd.sub) begin
         late_ge_ff  <= late_ge_in;
         early_ge_ff <= early_ge_in;
      end
      if (cmd.finish) begin
         out_dev_ff    <= dev_ff;
         out_late_ff   <= sat_out({1'b0, late_in});
         out_early_ff  <= sat_out({1'b0, early_in});
         out_margin_ff <= sat_out({1'b0, acc_sum[ACC_W:1]});
      end
   end

   assign status.div_idle  = !late_busy && !early_busy;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_deviation     = out_dev_ff;
   assign rsp_late_average  = out_late_ff;
   assign rsp_early_average = out_early_ff;
   assign rsp_margin        = out_margin_ff;

endmodule
`default_nettype wire

FILE: design/pjt_controller.sv
`timescale 1ns / 1ps
`default_nettype none
module pjt_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire pjt_pkg::status_type  status,
   output pjt_pkg::cmd_type          cmd
);
   import pjt_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_DEV;
         ST_DEV: state_in = ST_SUB;
         ST_SUB: state_in = ST_DIV;
         ST_DIV: begin
            if (status.div_idle) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_ready && req_valid;
   assign cmd.mul    = (state_ff == ST_MUL);
   assign cmd.dev    = (state_ff == ST_DEV);
   assign cmd.sub    = (state_ff == ST_SUB);
   assign cmd.finish = (state_ff == ST_FIN) && status.out_free;

endmodule
`default_nettype wire
